### sv/cqrp_pkg.sv
// Shared types and codes for the circular queue with rear removal.
`default_nettype none
package cqrp_pkg;

    // Operation codes carried by each input beat; codes above FN_POPREAR do nothing.
    localparam logic [2:0] FN_NONE    = 3'd0;
    localparam logic [2:0] FN_CLEAR   = 3'd1;
    localparam logic [2:0] FN_ENQ     = 3'd2;
    localparam logic [2:0] FN_DEQ     = 3'd3;
    localparam logic [2:0] FN_POPREAR = 3'd4;

    localparam int unsigned WORD_W = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_RESP
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic exec;
        logic load;
    } t_cmd;

endpackage
`default_nettype wire

### sv/cqrp_ram.sv
// Generic RAM with one write port and two registered read ports.
`default_nettype none
module cqrp_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule
`default_nettype wire

### sv/cqrp_ctrl.sv
// Sequencer that steps one operation through execute, read and respond phases.
`default_nettype none
module cqrp_ctrl (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_start,
    output logic        o_busy,
    output cqrp_pkg::t_cmd o_cmd
);

    cqrp_pkg::t_state r_state;
    cqrp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cqrp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_busy       = 1'b1;
        unique case (r_state)
            cqrp_pkg::ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    n_state      = cqrp_pkg::ST_EXEC;
                end
            end
            cqrp_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = cqrp_pkg::ST_READ;
            end
            // The RAM samples the updated front and rear addresses here.
            cqrp_pkg::ST_READ: begin
                n_state = cqrp_pkg::ST_RESP;
            end
            cqrp_pkg::ST_RESP: begin
                o_cmd.load = 1'b1;
                n_state    = cqrp_pkg::ST_IDLE;
            end
            default: begin
                n_state = cqrp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### sv/cqrp_dp.sv
// Pointers, count, slot storage and result registers of the queue.
`default_nettype none
module cqrp_dp #(
    parameter int unsigned CAPACITY = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire cqrp_pkg::t_cmd                i_cmd,
    input  wire logic [2:0]                    i_func,
    input  wire logic [cqrp_pkg::WORD_W-1:0]   i_push_value,
    output logic                               o_valid,
    output logic      [cqrp_pkg::WORD_W-1:0]   o_removed_value,
    output logic                               o_removed_valid,
    output logic      [$clog2(CAPACITY+1)-1:0] o_occupancy,
    output logic      [cqrp_pkg::WORD_W-1:0]   o_head_value,
    output logic      [cqrp_pkg::WORD_W-1:0]   o_tail_value,
    output logic                               o_is_empty,
    output logic                               o_is_full,
    output logic                               o_overflow
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned W  = cqrp_pkg::WORD_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic [2:0]    r_func;
    logic [W-1:0]  r_push;
    logic [W-1:0]  r_removed, n_removed;
    logic          r_rvalid, n_rvalid;
    logic          r_ovf, n_ovf;
    logic [W-1:0]  r_head_val;
    logic [W-1:0]  r_tail_val;
    logic          r_valid;

    logic          we;
    logic [AW-1:0] tail_prev;
    logic [AW-1:0] head_next;
    logic [AW-1:0] tail_next;
    logic [W-1:0]  rd_head;
    logic [W-1:0]  rd_tail;
    logic          is_empty;

    assign is_empty  = (r_count == '0);
    assign head_next = (r_head == LAST_IDX) ? '0 : r_head + AW'(1);
    assign tail_next = (r_tail == LAST_IDX) ? '0 : r_tail + AW'(1);
    assign tail_prev = (r_tail == '0) ? LAST_IDX : r_tail - AW'(1);

    // Removals take their word from the front and rear values cached by the
    // previous operation, so only the write and the two refresh reads touch the RAM.
    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_removed = '0;
        n_rvalid  = 1'b0;
        n_ovf     = 1'b0;
        we        = 1'b0;
        case (r_func)
            cqrp_pkg::FN_CLEAR: begin
                n_head  = '0;
                n_tail  = '0;
                n_count = '0;
            end
            cqrp_pkg::FN_ENQ: begin
                if (r_count == FULL_CNT) begin
                    n_ovf = 1'b1;
                end else begin
                    we      = i_cmd.exec;
                    n_tail  = tail_next;
                    n_count = r_count + CW'(1);
                end
            end
            cqrp_pkg::FN_DEQ: begin
                if (!is_empty) begin
                    n_removed = r_head_val;
                    n_rvalid  = 1'b1;
                    n_head    = head_next;
                    n_count   = r_count - CW'(1);
                end
            end
            cqrp_pkg::FN_POPREAR: begin
                if (!is_empty) begin
                    n_removed = r_tail_val;
                    n_rvalid  = 1'b1;
                    n_tail    = tail_prev;
                    n_count   = r_count - CW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    cqrp_ram #(
        .WIDTH (W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (r_tail),
        .i_wdata   (r_push),
        .i_raddr_a (r_head),
        .i_raddr_b (tail_prev),
        .o_rdata_a (rd_head),
        .o_rdata_b (rd_tail)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.load;
            if (i_cmd.exec) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func <= i_func;
            r_push <= i_push_value;
        end
        if (i_cmd.exec) begin
            r_removed <= n_removed;
            r_rvalid  <= n_rvalid;
            r_ovf     <= n_ovf;
        end
        if (i_cmd.load) begin
            r_head_val <= is_empty ? '0 : rd_head;
            r_tail_val <= is_empty ? '0 : rd_tail;
        end
    end

    assign o_valid         = r_valid;
    assign o_removed_value = r_removed;
    assign o_removed_valid = r_rvalid;
    assign o_occupancy     = r_count;
    assign o_head_value    = r_head_val;
    assign o_tail_value    = r_tail_val;
    assign o_is_empty      = is_empty;
    assign o_is_full       = (r_count == FULL_CNT);
    assign o_overflow      = r_ovf;

endmodule
`default_nettype wire

### sv/circular_queue_with_rear_pop_top.sv
// Top level of the ring-buffer queue with front dequeue and rear removal.
// An operation is taken when start is high and busy is low; busy then stays high
// through the execute, read and respond steps, and the result beat follows the
// respond step, marked by o_valid for exactly one cycle, so operations never
// overlap. These steps are set by the slot RAM: the operation's write lands
// first, then the RAM's registered read fetches the new front and rear words,
// then the result is registered. The result cannot be stalled and must be taken
// in the cycle o_valid is high; a new start may be issued in that same cycle. An
// enqueue into a full queue is dropped and reported as overflow.
`default_nettype none
module circular_queue_with_rear_pop_top #(
    parameter int unsigned CAPACITY = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [2:0]                    i_func,
    input  wire logic signed [31:0]            i_push_value,
    output logic                               o_valid,
    output logic signed [31:0]                 o_removed_value,
    output logic                               o_removed_valid,
    output logic      [$clog2(CAPACITY+1)-1:0] o_occupancy,
    output logic signed [31:0]                 o_head_value,
    output logic signed [31:0]                 o_tail_value,
    output logic                               o_is_empty,
    output logic                               o_is_full,
    output logic                               o_overflow
);

    cqrp_pkg::t_cmd cmd;

    cqrp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    cqrp_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_func          (i_func),
        .i_push_value    (i_push_value),
        .o_valid         (o_valid),
        .o_removed_value (o_removed_value),
        .o_removed_valid (o_removed_valid),
        .o_occupancy     (o_occupancy),
        .o_head_value    (o_head_value),
        .o_tail_value    (o_tail_value),
        .o_is_empty      (o_is_empty),
        .o_is_full       (o_is_full),
        .o_overflow      (o_overflow)
    );

endmodule
`default_nettype wire

### sv/cqrp_checker.sv
// Port-level checks for the queue top level, attached by bind.
`default_nettype none
module cqrp_checker #(
    parameter int unsigned CAPACITY = 16
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic                          o_valid,
    input wire logic [31:0]                   o_removed_value,
    input wire logic                          o_removed_valid,
    input wire logic [$clog2(CAPACITY+1)-1:0] o_occupancy,
    input wire logic [31:0]                   o_head_value,
    input wire logic [31:0]                   o_tail_value,
    input wire logic                          o_is_empty,
    input wire logic                          o_is_full,
    input wire logic                          o_overflow
);

    // An accepted beat keeps the block busy in the following cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy low right after an accepted beat");

    // A result strobe is never held high back to back.
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_empty == (o_occupancy == '0)))
        else $error("empty flag disagrees with occupancy");

    a_empty_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_empty |-> (o_head_value == '0) && (o_tail_value == '0))
        else $error("front or rear word nonzero on an empty queue");

    // A dropped enqueue leaves the queue full and removes nothing.
    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow |-> o_is_full && !o_removed_valid &&
        (o_removed_value == '0))
        else $error("overflow reported on a queue that is not full");

endmodule

bind circular_queue_with_rear_pop_top cqrp_checker #(
    .CAPACITY (CAPACITY)
) u_cqrp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_valid         (o_valid),
    .o_removed_value (o_removed_value),
    .o_removed_valid (o_removed_valid),
    .o_occupancy     (o_occupancy),
    .o_head_value    (o_head_value),
    .o_tail_value    (o_tail_value),
    .o_is_empty      (o_is_empty),
    .o_is_full       (o_is_full),
    .o_overflow      (o_overflow)
);
`default_nettype wire
